@@ sv/kfi_pkg.sv @@
// ----------------------------------------------------------------------------
// kfi_pkg
// Shared types, codes and helpers of the keyframe interpolator: request and
// response records, datapath commands, controller states and value helpers.
// ----------------------------------------------------------------------------
package kfi_pkg;

   localparam int VALUE_W = 48;
   localparam int TIME_W  = 32;
   localparam int FLAG_W  = 5;
   localparam int NUM_CH  = 4;

   localparam logic       ACTION_LOAD  = 1'b0;
   localparam logic       ACTION_QUERY = 1'b1;

   localparam logic [1:0] KIND_SCALAR = 2'd0;
   localparam logic [1:0] KIND_COLOR  = 2'd1;
   localparam logic [1:0] KIND_VECTOR = 2'd2;

   localparam logic signed [VALUE_W-1:0] CH_MAX = 48'sd255;

   typedef struct packed {
      logic                      action;
      logic                      first_key;
      logic signed [TIME_W-1:0]  time_num;
      logic [TIME_W-1:0]         time_scale;
      logic                      hold;
      logic [1:0]                kind;
      logic [1:0]                comp_cnt;
      logic signed [VALUE_W-1:0] value_0;
      logic signed [VALUE_W-1:0] value_1;
      logic signed [VALUE_W-1:0] value_2;
      logic signed [VALUE_W-1:0] value_3;
   } kfi_req_type;

   typedef struct packed {
      logic [1:0]                out_kind;
      logic [1:0]                out_comp_cnt;
      logic signed [VALUE_W-1:0] out_value_0;
      logic signed [VALUE_W-1:0] out_value_1;
      logic signed [VALUE_W-1:0] out_value_2;
      logic signed [VALUE_W-1:0] out_value_3;
      logic                      query_error;
   } kfi_rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_ERR,
      OP_CAPT,
      OP_MUL_X,
      OP_MUL_Y,
      OP_INC,
      OP_EMIT_L,
      OP_EMIT_R,
      OP_MUL_A,
      OP_MUL_B,
      OP_DIFF,
      OP_NUM_LO,
      OP_NUM_HI,
      OP_DEN_LO,
      OP_DEN_HI,
      OP_FSET,
      OP_DIV,
      OP_LD,
      OP_LLO,
      OP_LHI,
      OP_LRND,
      OP_PUB
   } kfi_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_CHECK,
      S_RD,
      S_CAPT,
      S_MX,
      S_MY,
      S_CMP,
      S_MA,
      S_MB,
      S_DIFF,
      S_NLO,
      S_NHI,
      S_DLO,
      S_DHI,
      S_FSET,
      S_DIV,
      S_LD,
      S_LLO,
      S_LHI,
      S_LRND,
      S_PUB
   } kfi_state_type;

   typedef struct packed {
      logic err;
      logic lt_yx;
      logic lt_xy;
      logic idx_zero;
      logic idx_last;
      logic pass_left;
      logic frac_zero;
      logic frac_one;
      logic div_last;
      logic ch_last;
   } kfi_status_type;

   function automatic logic signed [VALUE_W-1:0] clamp_ch(input logic signed [VALUE_W-1:0] v);
      logic signed [VALUE_W-1:0] r;
      if (v < 0) r = '0;
      else if (v > CH_MAX) r = CH_MAX;
      else r = v;
      return r;
   endfunction

   function automatic logic ch_used(input logic [1:0] kind, input logic [1:0] cnt,
                                    input logic [1:0] c);
      logic u;
      if (kind == KIND_COLOR) u = 1'b1;
      else if (kind == KIND_SCALAR) u = (c == 2'd0);
      else u = (c < cnt);
      return u;
   endfunction

endpackage

@@ sv/keyframe_interpolator_top.sv @@
// ----------------------------------------------------------------------------
// keyframe_interpolator_top
// Keyframe store with rational-time query and linear interpolation.
//
//   channel  direction  signals                         transfer
//   req      in         req_valid req_ready req_data    load key or query
//   rsp      out        rsp_valid rsp_ready rsp_data    one per query
//
// a load writes the key store; a query is checked, then searches the keys
// one after another and, when it interpolates, runs the division and lerp steps
// (the division steps are skipped for a fraction of zero or one)
// the shared 33x33 multiplier and the one-bit-per-cycle divider set a query's time
// reset is synchronous; the key store needs no clearing pass
// a finished result waits in the response register while the next item is taken
// ----------------------------------------------------------------------------
module keyframe_interpolator_top #(
   parameter int MAX_KEYS      = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  kfi_pkg::kfi_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kfi_pkg::kfi_rsp_type rsp_data
);
   import kfi_pkg::*;

   kfi_op_type     op;
   kfi_status_type status;

   kfi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .rsp_ready  (rsp_ready),
      .status     (status),
      .op         (op),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid)
   );

   kfi_dp #(
      .MAX_KEYS      (MAX_KEYS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

@@ sv/kfi_ram.sv @@
// ----------------------------------------------------------------------------
// kfi_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module kfi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/kfi_dp.sv @@
// ----------------------------------------------------------------------------
// kfi_dp
// Key store, shared multiplier, restoring divider and lerp rounding of the
// keyframe interpolator, driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module kfi_dp #(
   parameter int MAX_KEYS      = 16,
   parameter int FRACTION_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kfi_pkg::kfi_op_type    op,
   input  kfi_pkg::kfi_req_type   req_data,
   output kfi_pkg::kfi_status_type status,
   output kfi_pkg::kfi_rsp_type   rsp_data
);
   import kfi_pkg::*;

   localparam int IW     = $clog2(MAX_KEYS);
   localparam int CW     = $clog2(MAX_KEYS + 1);
   localparam int FW     = FRACTION_BITS + 1;
   localparam int AW     = VALUE_W + FW;
   localparam int DCW    = $clog2(FRACTION_BITS);
   localparam int META_W = 2 * TIME_W + FLAG_W;
   localparam int VALS_W = NUM_CH * VALUE_W;
   localparam int WIDE_W = 3 * TIME_W;
   localparam int PW     = 2 * TIME_W;
   localparam int MW     = TIME_W + 1;

   localparam logic [AW-1:0] HALF     = AW'(1) << (FRACTION_BITS - 1);
   localparam logic [AW-1:0] LOW_MASK = (AW'(1) << FRACTION_BITS) - AW'(1);

   logic [CW-1:0]             held_ff, held_in;
   logic [IW-1:0]             idx_ff;
   logic signed [TIME_W-1:0]  t_ff, lt_ff, rt_ff;
   logic [TIME_W-1:0]         s_ff, ls_ff, rs_ff;
   logic [FLAG_W-1:0]         lf_ff, rf_ff;
   logic signed [VALUE_W-1:0] lv_ff [NUM_CH];
   logic signed [VALUE_W-1:0] rv_ff [NUM_CH];
   logic signed [PW-1:0]      x_ff, y_ff, xl_ff, yl_ff, pa_ff, pb_ff;
   logic [PW-1:0]             nm_ff, dm_ff;
   logic                      nn_ff, dn_ff;
   logic [WIDE_W-1:0]         num_ff, den_ff;
   logic [WIDE_W:0]           rem_ff;
   logic [FW-1:0]             f_ff;
   logic [DCW-1:0]            dcnt_ff;
   logic [1:0]                ch_ff;
   logic signed [VALUE_W-1:0] a_ff;
   logic signed [VALUE_W:0]   d_ff;
   logic [AW-1:0]             lacc_ff;
   kfi_rsp_type               wk_ff, out_ff;

   logic                      wr_en;
   logic [IW-1:0]             wr_addr;
   logic [META_W-1:0]         meta_rd;
   logic [VALS_W-1:0]         vals_rd;

   logic signed [MW-1:0]      mul_a, mul_b;
   logic signed [2*MW-1:0]    mp;
   logic [VALUE_W:0]          m_full;
   logic [VALUE_W-1:0]        m;
   logic signed [VALUE_W-1:0] cl_l [NUM_CH];
   logic signed [VALUE_W-1:0] cl_r [NUM_CH];
   logic [WIDE_W:0]           rem2, rem_in;
   logic                      ge;
   logic [AW-1:0]             up, dnv;
   logic signed [VALUE_W+1:0] sa, r_pos, r_neg;
   logic signed [VALUE_W-1:0] lres;

   // key store
   assign wr_en   = (op == OP_ACCEPT) && (req_data.action == ACTION_LOAD) &&
                    (req_data.first_key || (held_ff != CW'(MAX_KEYS)));
   assign wr_addr = req_data.first_key ? '0 : held_ff[IW-1:0];
   assign held_in = wr_en ? (CW'(wr_addr) + CW'(1)) : held_ff;

   kfi_ram #(.WIDTH(META_W), .DEPTH(MAX_KEYS)) u_meta_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.time_num, req_data.time_scale,
                 req_data.comp_cnt, req_data.kind, req_data.hold}),
      .rd_addr (idx_ff),
      .rd_data (meta_rd)
   );

   kfi_ram #(.WIDTH(VALS_W), .DEPTH(MAX_KEYS)) u_vals_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({req_data.value_3, req_data.value_2, req_data.value_1, req_data.value_0}),
      .rd_addr (idx_ff),
      .rd_data (vals_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (op)
         OP_MUL_X: begin
            mul_a = {t_ff[TIME_W-1], t_ff};
            mul_b = {1'b0, rs_ff};
         end
         OP_MUL_Y: begin
            mul_a = {rt_ff[TIME_W-1], rt_ff};
            mul_b = {1'b0, s_ff};
         end
         OP_MUL_A: begin
            mul_a = {rt_ff[TIME_W-1], rt_ff};
            mul_b = {1'b0, ls_ff};
         end
         OP_MUL_B: begin
            mul_a = {lt_ff[TIME_W-1], lt_ff};
            mul_b = {1'b0, rs_ff};
         end
         OP_NUM_LO: begin
            mul_a = {1'b0, nm_ff[TIME_W-1:0]};
            mul_b = {1'b0, rs_ff};
         end
         OP_NUM_HI: begin
            mul_a = {1'b0, nm_ff[PW-1:TIME_W]};
            mul_b = {1'b0, rs_ff};
         end
         OP_DEN_LO: begin
            mul_a = {1'b0, dm_ff[TIME_W-1:0]};
            mul_b = {1'b0, s_ff};
         end
         OP_DEN_HI: begin
            mul_a = {1'b0, dm_ff[PW-1:TIME_W]};
            mul_b = {1'b0, s_ff};
         end
         OP_LLO: begin
            mul_a = {1'b0, m[TIME_W-1:0]};
            mul_b = {{(MW-FW){1'b0}}, f_ff};
         end
         OP_LHI: begin
            mul_a = {{(MW-(VALUE_W-TIME_W)){1'b0}}, m[VALUE_W-1:TIME_W]};
            mul_b = {{(MW-FW){1'b0}}, f_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mp = mul_a * mul_b;

   // key values, clamped for color keys
   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         cl_l[c] = (lf_ff[2:1] == KIND_COLOR) ? clamp_ch(lv_ff[c]) : lv_ff[c];
         cl_r[c] = (rf_ff[2:1] == KIND_COLOR) ? clamp_ch(rv_ff[c]) : rv_ff[c];
      end
   end

   // divider step
   assign rem2   = {rem_ff[WIDE_W-1:0], 1'b0};
   assign ge     = rem2 >= {1'b0, den_ff};
   assign rem_in = ge ? (rem2 - {1'b0, den_ff}) : rem2;

   // lerp rounding
   assign m_full = d_ff[VALUE_W] ? (VALUE_W+1)'(-d_ff) : d_ff;
   assign m      = m_full[VALUE_W-1:0];
   assign up     = lacc_ff + HALF;
   assign dnv    = lacc_ff - HALF + LOW_MASK;
   assign sa     = {a_ff[VALUE_W-1], a_ff[VALUE_W-1], a_ff};
   assign r_pos  = sa + {1'b0, up[FRACTION_BITS +: VALUE_W+1]};
   assign r_neg  = (lacc_ff <= HALF) ? sa : (sa - {1'b0, dnv[FRACTION_BITS +: VALUE_W+1]});
   assign lres   = d_ff[VALUE_W] ? r_neg[VALUE_W-1:0] : r_pos[VALUE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         dcnt_ff <= '0;
         ch_ff   <= '0;
      end else begin
         case (op)
            OP_ACCEPT: idx_ff  <= '0;
            OP_INC:    idx_ff  <= idx_ff + IW'(1);
            OP_FSET: begin
               dcnt_ff <= '0;
               ch_ff   <= '0;
            end
            OP_DIV:    dcnt_ff <= dcnt_ff + DCW'(1);
            OP_LRND:   ch_ff   <= ch_ff + 2'd1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (op)
         OP_ACCEPT: begin
            t_ff <= req_data.time_num;
            s_ff <= req_data.time_scale;
         end
         OP_ERR: begin
            wk_ff <= '{query_error: 1'b1, default: '0};
         end
         OP_CAPT: begin
            lt_ff <= rt_ff;
            ls_ff <= rs_ff;
            lf_ff <= rf_ff;
            xl_ff <= x_ff;
            yl_ff <= y_ff;
            {rt_ff, rs_ff, rf_ff} <= meta_rd;
            for (int c = 0; c < NUM_CH; c++) begin
               lv_ff[c] <= rv_ff[c];
               rv_ff[c] <= vals_rd[c*VALUE_W +: VALUE_W];
            end
         end
         OP_MUL_X: x_ff  <= mp[PW-1:0];
         OP_MUL_Y: y_ff  <= mp[PW-1:0];
         OP_MUL_A: pa_ff <= mp[PW-1:0];
         OP_MUL_B: pb_ff <= mp[PW-1:0];
         OP_EMIT_L: begin
            wk_ff.out_kind     <= lf_ff[2:1];
            wk_ff.out_comp_cnt <= lf_ff[4:3];
            wk_ff.out_value_0 <= ch_used(lf_ff[2:1], lf_ff[4:3], 2'd0) ? cl_l[0] : '0;
            wk_ff.out_value_1 <= ch_used(lf_ff[2:1], lf_ff[4:3], 2'd1) ? cl_l[1] : '0;
            wk_ff.out_value_2 <= ch_used(lf_ff[2:1], lf_ff[4:3], 2'd2) ? cl_l[2] : '0;
            wk_ff.out_value_3 <= ch_used(lf_ff[2:1], lf_ff[4:3], 2'd3) ? cl_l[3] : '0;
            wk_ff.query_error <= 1'b0;
         end
         OP_EMIT_R: begin
            wk_ff.out_kind     <= rf_ff[2:1];
            wk_ff.out_comp_cnt <= rf_ff[4:3];
            wk_ff.out_value_0 <= ch_used(rf_ff[2:1], rf_ff[4:3], 2'd0) ? cl_r[0] : '0;
            wk_ff.out_value_1 <= ch_used(rf_ff[2:1], rf_ff[4:3], 2'd1) ? cl_r[1] : '0;
            wk_ff.out_value_2 <= ch_used(rf_ff[2:1], rf_ff[4:3], 2'd2) ? cl_r[2] : '0;
            wk_ff.out_value_3 <= ch_used(rf_ff[2:1], rf_ff[4:3], 2'd3) ? cl_r[3] : '0;
            wk_ff.query_error <= 1'b0;
         end
         OP_DIFF: begin
            nn_ff <= xl_ff < yl_ff;
            nm_ff <= (xl_ff >= yl_ff) ? PW'(xl_ff - yl_ff) : PW'(yl_ff - xl_ff);
            dn_ff <= pa_ff < pb_ff;
            dm_ff <= (pa_ff >= pb_ff) ? PW'(pa_ff - pb_ff) : PW'(pb_ff - pa_ff);
            wk_ff.out_kind     <= lf_ff[2:1];
            wk_ff.out_comp_cnt <= lf_ff[4:3];
            wk_ff.query_error  <= 1'b0;
         end
         OP_NUM_LO: num_ff <= {{TIME_W{1'b0}}, mp[PW-1:0]};
         OP_NUM_HI: num_ff <= num_ff + {mp[PW-1:0], {TIME_W{1'b0}}};
         OP_DEN_LO: den_ff <= {{TIME_W{1'b0}}, mp[PW-1:0]};
         OP_DEN_HI: den_ff <= den_ff + {mp[PW-1:0], {TIME_W{1'b0}}};
         OP_FSET: begin
            rem_ff <= {1'b0, num_ff};
            if (status.frac_zero) f_ff <= '0;
            else if (status.frac_one) f_ff <= FW'(1) << FRACTION_BITS;
            else f_ff <= '0;
         end
         OP_DIV: begin
            rem_ff <= rem_in;
            f_ff   <= {f_ff[FW-2:0], ge};
         end
         OP_LD: begin
            a_ff <= cl_l[ch_ff];
            d_ff <= {cl_r[ch_ff][VALUE_W-1], cl_r[ch_ff]} - {cl_l[ch_ff][VALUE_W-1], cl_l[ch_ff]};
         end
         OP_LLO: lacc_ff <= AW'(mp[PW-1:0]);
         OP_LHI: lacc_ff <= lacc_ff + AW'({mp[PW-1:0], {TIME_W{1'b0}}});
         OP_LRND: begin
            case (ch_ff)
               2'd0: wk_ff.out_value_0 <=
                  ch_used(wk_ff.out_kind, wk_ff.out_comp_cnt, 2'd0) ? lres : '0;
               2'd1: wk_ff.out_value_1 <=
                  ch_used(wk_ff.out_kind, wk_ff.out_comp_cnt, 2'd1) ? lres : '0;
               2'd2: wk_ff.out_value_2 <=
                  ch_used(wk_ff.out_kind, wk_ff.out_comp_cnt, 2'd2) ? lres : '0;
               default: wk_ff.out_value_3 <=
                  ch_used(wk_ff.out_kind, wk_ff.out_comp_cnt, 2'd3) ? lres : '0;
            endcase
         end
         OP_PUB: out_ff <= wk_ff;
         default: begin
         end
      endcase
   end

   always_comb begin
      status.err       = (s_ff == '0) || (held_ff == '0);
      status.lt_yx     = y_ff < x_ff;
      status.lt_xy     = x_ff < y_ff;
      status.idx_zero  = (idx_ff == '0);
      status.idx_last  = ((CW'(idx_ff) + CW'(1)) == held_ff);
      status.pass_left = lf_ff[0] || (lf_ff[4:1] != rf_ff[4:1]);
      status.frac_zero = (den_ff == '0) || (num_ff == '0) || (nn_ff != dn_ff);
      status.frac_one  = num_ff >= den_ff;
      status.div_last  = (dcnt_ff == DCW'(FRACTION_BITS - 1));
      status.ch_last   = (ch_ff == 2'd3);
   end

   assign rsp_data = out_ff;

endmodule

@@ sv/kfi_ctrl.sv @@
// ----------------------------------------------------------------------------
// kfi_ctrl
// Sequencer of the keyframe interpolator: key search, fraction, division,
// per-channel lerp and the response register handshake.
// ----------------------------------------------------------------------------
module kfi_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_action,
   input  logic                    rsp_ready,
   input  kfi_pkg::kfi_status_type status,
   output kfi_pkg::kfi_op_type     op,
   output logic                    req_ready,
   output logic                    rsp_valid
);
   import kfi_pkg::*;

   kfi_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op = OP_ACCEPT;
               if (req_action == ACTION_QUERY) state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.err) begin
               op       = OP_ERR;
               state_in = S_PUB;
            end else begin
               state_in = S_CAPT;
            end
         end
         S_RD:   state_in = S_CAPT;
         S_CAPT: begin
            op       = OP_CAPT;
            state_in = S_MX;
         end
         S_MX: begin
            op       = OP_MUL_X;
            state_in = S_MY;
         end
         S_MY: begin
            op       = OP_MUL_Y;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (status.idx_zero && !status.lt_yx) begin
               op       = OP_EMIT_R;
               state_in = S_PUB;
            end else if (!status.idx_zero && status.lt_xy) begin
               if (status.pass_left) begin
                  op       = OP_EMIT_L;
                  state_in = S_PUB;
               end else begin
                  state_in = S_MA;
               end
            end else if (status.idx_last) begin
               op       = OP_EMIT_R;
               state_in = S_PUB;
            end else begin
               op       = OP_INC;
               state_in = S_RD;
            end
         end
         S_MA: begin
            op       = OP_MUL_A;
            state_in = S_MB;
         end
         S_MB: begin
            op       = OP_MUL_B;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            op       = OP_DIFF;
            state_in = S_NLO;
         end
         S_NLO: begin
            op       = OP_NUM_LO;
            state_in = S_NHI;
         end
         S_NHI: begin
            op       = OP_NUM_HI;
            state_in = S_DLO;
         end
         S_DLO: begin
            op       = OP_DEN_LO;
            state_in = S_DHI;
         end
         S_DHI: begin
            op       = OP_DEN_HI;
            state_in = S_FSET;
         end
         S_FSET: begin
            op       = OP_FSET;
            state_in = (status.frac_zero || status.frac_one) ? S_LD : S_DIV;
         end
         S_DIV: begin
            op = OP_DIV;
            if (status.div_last) state_in = S_LD;
         end
         S_LD: begin
            op       = OP_LD;
            state_in = S_LLO;
         end
         S_LLO: begin
            op       = OP_LLO;
            state_in = S_LHI;
         end
         S_LHI: begin
            op       = OP_LHI;
            state_in = S_LRND;
         end
         S_LRND: begin
            op       = OP_LRND;
            state_in = status.ch_last ? S_PUB : S_LD;
         end
         S_PUB: begin
            if (!rsp_valid_ff || rsp_ready) begin
               op       = OP_PUB;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = (op == OP_PUB) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;

`ifndef SYNTHESIS
   a_pub_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_PUB) |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register overwritten");
   a_valid_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(op == OP_PUB))
      else $error("response valid without publish");
   a_query_go: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_action == ACTION_QUERY)) |=> (state_ff == S_CHECK))
      else $error("query transfer did not start search");
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && status.div_last) |=> (state_ff == S_LD))
      else $error("division did not end");
`endif

endmodule
